[hw/rtl/mtc_pkg.sv]
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared codes, character constants and control types for the Morse tree codec.
// ----------------------------------------------------------------------------
`default_nettype none

package mtc_pkg;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_DECODE = 2'd2;

  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_SEP      = 8'h2F;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef struct packed {
    logic start;
    logic step;
  } walk_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/mtc_if.sv]
// ----------------------------------------------------------------------------
// mtc_if
// Valid/ready channels of the Morse tree codec: item input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] entry_index;
  logic [7:0] entry_char;
  logic [7:0] char_in;

  modport source (output valid, command, entry_index, entry_char, char_in, input ready);
  modport sink   (input valid, command, entry_index, entry_char, char_in, output ready);
endinterface

interface mtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, char_out, last, input ready);
  modport sink   (input valid, char_out, last, output ready);
endinterface

`default_nettype wire

[hw/rtl/morse_tree_codec.sv]
// ----------------------------------------------------------------------------
// morse_tree_codec
// Morse code codec over a heap-indexed tree table (dot 2i+1, dash 2i+2).
//
// Input channel in_ch carries one command per transfer: load a table entry,
// encode one byte, or decode one byte of Morse text. Output channel out_ch
// carries result bytes; last marks the final result of an item.
// A load gives no result. A decode separator after a code within the tree
// reads the table in S_LOOKUP before its result. An encode runs the tree
// walker over the table, one entry per cycle through the single read port,
// until a match or the end of the tree, then sends its symbols, at most
// TREE_LEVELS results in all.
// in_ch.ready is high only between items; one item is worked on at a time.
// Results leave through an output register, so the last result of an item
// may wait on a stalled receiver while the next item is taken; a stall
// otherwise holds the sequencer.
// Reset clears the decode path and the output register. The table is not
// cleared and must be loaded before any encode or table read.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_tree_codec #(
  parameter int TREE_LEVELS = 8
) (
  input wire logic clk,
  input wire logic rst,
  mtc_in_if.sink   in_ch,
  mtc_out_if.source out_ch
);

  localparam int CW = $clog2(TREE_LEVELS);
  localparam logic [8:0] TABLE_SIZE = 9'((1 << TREE_LEVELS) - 1);
  localparam logic [3:0] LEN_MAX    = 4'(TREE_LEVELS - 1);
  localparam logic [3:0] LEN_SAT    = 4'(TREE_LEVELS);
  localparam logic [TREE_LEVELS-1:0] P_ROOT = {{(TREE_LEVELS-1){1'b0}}, 1'b1};

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_LOOKUP,
    S_PRE,
    S_EMIT
  } state_t;

  state_t                 state;
  logic                   out_valid;
  logic [7:0]             out_char;
  logic                   out_last;
  logic [7:0]             ch_reg;
  logic [7:0]             pre_char;
  logic                   pre_last;
  logic [TREE_LEVELS-1:0] emit_p;
  logic [CW-1:0]          emit_cnt;
  logic [TREE_LEVELS-1:0] path_node;
  logic [3:0]             path_length;
  logic                   chk_valid;
  logic [TREE_LEVELS-1:0] chk_p;

  logic                   accept;
  logic                   out_free;
  logic                   load_out;
  logic [7:0]             ch_up;
  logic                   is_eol;
  logic                   tbl_we;
  logic                   tbl_re;
  logic [TREE_LEVELS-1:0] tbl_raddr;
  logic [7:0]             tbl_rdata;
  logic                   search_issue;
  logic                   found;
  mtc_pkg::walk_ctl_t     walk_ctl;
  logic [TREE_LEVELS-1:0] walk_p;
  logic                   walk_active;
  logic [TREE_LEVELS:0]   path_ext;
  logic [CW-1:0]          emit_idx;

  function automatic logic [CW-1:0] node_depth(input logic [TREE_LEVELS-1:0] v);
    logic [CW-1:0] d;
    d = '0;
    for (int i = 0; i < TREE_LEVELS; i++) begin
      if (v[i]) begin
        d = CW'(i);
      end
    end
    return d;
  endfunction

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == S_IDLE);
  assign out_free     = !out_valid || out_ch.ready;
  assign load_out     = out_free && (state inside {S_PRE, S_EMIT});
  assign out_ch.valid    = out_valid;
  assign out_ch.char_out = out_char;
  assign out_ch.last     = out_last;

  assign ch_up = (in_ch.char_in inside {[mtc_pkg::CH_LOWER_A:mtc_pkg::CH_LOWER_Z]})
               ? in_ch.char_in - mtc_pkg::CASE_OFFSET : in_ch.char_in;
  assign is_eol = (ch_up == mtc_pkg::CH_LF) || (ch_up == mtc_pkg::CH_CR);

  assign tbl_we = accept && (in_ch.command == mtc_pkg::CMD_LOAD)
               && ({1'b0, in_ch.entry_index} < TABLE_SIZE);

  assign search_issue = (state == S_SEARCH) && walk_active;
  assign found        = chk_valid && (tbl_rdata == ch_reg);

  assign tbl_re = search_issue
               || (accept && (in_ch.command == mtc_pkg::CMD_DECODE)
                   && (in_ch.char_in == mtc_pkg::CH_SEP));
  assign tbl_raddr = (state == S_SEARCH) ? walk_p - P_ROOT : path_node;

  assign walk_ctl.start = accept && (in_ch.command == mtc_pkg::CMD_ENCODE) && !is_eol;
  assign walk_ctl.step  = search_issue;

  assign path_ext = {path_node, 1'b0}
                  + ((in_ch.char_in == mtc_pkg::CH_DOT) ? (TREE_LEVELS+1)'(1)
                                                        : (TREE_LEVELS+1)'(2));
  assign emit_idx = emit_cnt - CW'(1);

  mtc_table #(.TREE_LEVELS(TREE_LEVELS)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_ch.entry_index[TREE_LEVELS-1:0]),
    .wdata (in_ch.entry_char),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  mtc_walk #(.TREE_LEVELS(TREE_LEVELS)) u_walk (
    .clk    (clk),
    .rst    (rst),
    .ctl    (walk_ctl),
    .p      (walk_p),
    .active (walk_active)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      path_node   <= '0;
      path_length <= '0;
      chk_valid   <= 1'b0;
    end else begin
      chk_valid <= search_issue;
      chk_p     <= walk_p;
      if (out_ch.ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_ch.command)
              mtc_pkg::CMD_ENCODE: begin
                ch_reg <= ch_up;
                if (is_eol) begin
                  pre_char <= ch_up;
                  pre_last <= 1'b0;
                  emit_cnt <= '0;
                  state    <= S_PRE;
                end else begin
                  state <= S_SEARCH;
                end
              end
              mtc_pkg::CMD_DECODE: begin
                if (in_ch.char_in inside {mtc_pkg::CH_DOT, mtc_pkg::CH_DASH}) begin
                  if (path_length < LEN_MAX) begin
                    path_node   <= path_ext[TREE_LEVELS-1:0];
                    path_length <= path_length + 4'd1;
                  end else begin
                    path_length <= LEN_SAT;
                  end
                end else begin
                  path_node   <= '0;
                  path_length <= '0;
                  if (in_ch.char_in == mtc_pkg::CH_SEP && path_length != 4'd0) begin
                    if (path_length <= LEN_MAX) begin
                      state <= S_LOOKUP;
                    end else begin
                      pre_char <= mtc_pkg::CH_SPACE;
                      pre_last <= 1'b1;
                      state    <= S_PRE;
                    end
                  end else if (in_ch.char_in == mtc_pkg::CH_SPACE) begin
                    pre_char <= mtc_pkg::CH_SPACE;
                    pre_last <= 1'b1;
                    state    <= S_PRE;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (found) begin
            if (chk_p == P_ROOT) begin
              pre_char <= mtc_pkg::CH_SPACE;
              pre_last <= 1'b0;
              emit_cnt <= '0;
              state    <= S_PRE;
            end else begin
              emit_p   <= chk_p;
              emit_cnt <= node_depth(chk_p);
              state    <= S_EMIT;
            end
          end else if (!chk_valid && !walk_active) begin
            pre_char <= mtc_pkg::CH_SPACE;
            pre_last <= 1'b0;
            emit_cnt <= '0;
            state    <= S_PRE;
          end
        end
        S_LOOKUP: begin
          pre_char <= tbl_rdata;
          pre_last <= 1'b1;
          state    <= S_PRE;
        end
        S_PRE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_char  <= pre_char;
            out_last  <= pre_last;
            state     <= pre_last ? S_IDLE : S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (emit_cnt == '0) begin
              out_char <= mtc_pkg::CH_SEP;
              out_last <= 1'b1;
              state    <= S_IDLE;
            end else begin
              out_char <= emit_p[emit_idx] ? mtc_pkg::CH_DASH : mtc_pkg::CH_DOT;
              out_last <= 1'b0;
              emit_cnt <= emit_idx;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_path_len_range: assert property (@(posedge clk) disable iff (rst)
    path_length <= LEN_SAT)
    else $error("decode path length beyond saturation");

  a_path_empty_root: assert property (@(posedge clk) disable iff (rst)
    path_length == 4'd0 |-> path_node == '0)
    else $error("empty decode path not at root");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.command == mtc_pkg::CMD_LOAD |=> state == S_IDLE)
    else $error("load item started a result sequence");

  a_walk_nonzero: assert property (@(posedge clk) disable iff (rst)
    walk_active |-> walk_p != '0)
    else $error("tree walker pointer lost its marker bit");

  a_found_in_search: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && emit_cnt != '0 |-> emit_p != '0)
    else $error("symbol emission without a found node");

endmodule

`default_nettype wire

[hw/rtl/mtc_table.sv]
// ----------------------------------------------------------------------------
// mtc_table
// Heap-indexed symbol table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_table #(
  parameter int TREE_LEVELS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [TREE_LEVELS-1:0] waddr,
  input  wire logic [7:0]             wdata,
  input  wire logic                   re,
  input  wire logic [TREE_LEVELS-1:0] raddr,
  output      logic [7:0]             rdata
);

  localparam int TABLE_SIZE = (1 << TREE_LEVELS) - 1;

  logic [7:0] mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mtc_walk.sv]
// ----------------------------------------------------------------------------
// mtc_walk
// Tree walker: steps a node pointer through the search order (node, dash
// subtree, dot subtree), one node per cycle on step; pointer is index plus one.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_walk #(
  parameter int TREE_LEVELS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire mtc_pkg::walk_ctl_t     ctl,
  output      logic [TREE_LEVELS-1:0] p,
  output      logic                   active
);

  logic [TREE_LEVELS-1:0] stripped;

  always_comb begin
    stripped = p;
    for (int i = 0; i < TREE_LEVELS - 1; i++) begin
      if (!stripped[0]) begin
        stripped = {1'b0, stripped[TREE_LEVELS-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      p      <= {{(TREE_LEVELS-1){1'b0}}, 1'b1};
    end else if (ctl.start) begin
      active <= 1'b1;
      p      <= {{(TREE_LEVELS-1){1'b0}}, 1'b1};
    end else if (ctl.step && active) begin
      if (!p[TREE_LEVELS-1]) begin
        p <= {p[TREE_LEVELS-2:0], 1'b1};
      end else if (stripped == {{(TREE_LEVELS-1){1'b0}}, 1'b1}) begin
        active <= 1'b0;
      end else begin
        p <= {stripped[TREE_LEVELS-1:1], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[tb/sv/morse_tree_codec_test.sv]
// ----------------------------------------------------------------------------
// morse_tree_codec_test
// Self-checking bench for the Morse tree codec. The tree table is loaded in
// full first, then a directed pass covers the corner cases and a random pass
// mixes well-formed Morse words, encodes, table reloads and noise. A shadow
// of the table and the decode path predicts every result byte, and results
// are checked in order against it. Both sides idle at random, and the
// receiver holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_tree_codec_test;

  localparam int TREE_LEVELS = 8;
  localparam int TABLE_SIZE = (1 << TREE_LEVELS) - 1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 120;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT_RESULT = 60;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] entry_index;
    logic [7:0] entry_char;
    logic [7:0] char_in;
  } codec_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } codec_byte_t;

  class symbol_scoreboard;
    logic [7:0]  tree [TABLE_SIZE];
    logic [7:0]  walk_node;
    logic [3:0]  walk_len;
    codec_byte_t pending_bytes [$];
    int          errors;

    function new();
      walk_node = '0;
      walk_len = '0;
      errors = 0;
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    function void push_byte(logic [7:0] c, logic l);
      codec_byte_t b;
      b.char_out = c;
      b.last = l;
      pending_bytes.push_back(b);
    endfunction

    // preorder walk; a matching node hides its subtree, last match wins
    function int find_code_node(logic [7:0] ch);
      int stack [$];
      int node;
      int found;
      found = -1;
      stack.push_back(0);
      while (stack.size() > 0) begin
        node = stack.pop_back();
        if (tree[node] == ch) begin
          found = node;
        end else if (2 * node + 2 < TABLE_SIZE) begin
          stack.push_back(2 * node + 2);
          stack.push_back(2 * node + 1);
        end
      end
      return found;
    endfunction

    function void encode_byte(logic [7:0] ch);
      logic [7:0] path [$];
      int node;
      if (ch >= mtc_pkg::CH_LOWER_A && ch <= mtc_pkg::CH_LOWER_Z) begin
        ch = ch - mtc_pkg::CASE_OFFSET;
      end
      if (ch == mtc_pkg::CH_LF || ch == mtc_pkg::CH_CR) begin
        push_byte(ch, 1'b0);
        push_byte(mtc_pkg::CH_SEP, 1'b1);
        return;
      end
      node = find_code_node(ch);
      if (node <= 0) begin
        push_byte(mtc_pkg::CH_SPACE, 1'b0);
        push_byte(mtc_pkg::CH_SEP, 1'b1);
        return;
      end
      while (node > 0) begin
        if (node % 2 == 1) begin
          path.push_front(mtc_pkg::CH_DOT);
          node = (node - 1) / 2;
        end else begin
          path.push_front(mtc_pkg::CH_DASH);
          node = (node - 2) / 2;
        end
      end
      foreach (path[i]) begin
        push_byte(path[i], 1'b0);
      end
      push_byte(mtc_pkg::CH_SEP, 1'b1);
    endfunction

    function void decode_byte(logic [7:0] ch);
      if (ch == mtc_pkg::CH_DOT || ch == mtc_pkg::CH_DASH) begin
        if (walk_len < TREE_LEVELS - 1) begin
          walk_node = 8'(2 * walk_node + ((ch == mtc_pkg::CH_DOT) ? 1 : 2));
          walk_len++;
        end else begin
          walk_len = 4'(TREE_LEVELS);
        end
        return;
      end
      if (ch == mtc_pkg::CH_SEP && walk_len > 0) begin
        push_byte((walk_len <= TREE_LEVELS - 1) ? tree[walk_node] : mtc_pkg::CH_SPACE,
                  1'b1);
      end else if (ch == mtc_pkg::CH_SPACE) begin
        push_byte(mtc_pkg::CH_SPACE, 1'b1);
      end
      walk_node = '0;
      walk_len = '0;
    endfunction

    function void note_item(codec_item_t it);
      case (it.command)
        mtc_pkg::CMD_LOAD: begin
          if (it.entry_index < TABLE_SIZE) begin
            tree[it.entry_index] = it.entry_char;
          end
        end
        mtc_pkg::CMD_ENCODE: begin
          encode_byte(it.char_in);
        end
        mtc_pkg::CMD_DECODE: begin
          decode_byte(it.char_in);
        end
        default: begin
        end
      endcase
    endfunction

    task check_output(logic [7:0] c, logic l);
      codec_byte_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected result char_out=%h last=%b", c, l));
        return;
      end
      want = pending_bytes.pop_front();
      if (c !== want.char_out) begin
        report($sformatf("char_out %h, wanted %h", c, want.char_out));
      end
      if (l !== want.last) begin
        report($sformatf("last %b on char_out %h, wanted %b", l, c, want.last));
      end
    endtask

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  mtc_in_if  in_ch ();
  mtc_out_if out_ch ();

  morse_tree_codec #(
    .TREE_LEVELS(TREE_LEVELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  symbol_scoreboard board = new();

  bit send_burst = 1'b0;
  bit take_burst = 1'b0;
  bit hold_done = 1'b0;
  int items_sent = 0;
  int results_seen = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic codec_item_t make_item(logic [1:0] cmd, logic [7:0] idx,
                                             logic [7:0] ech, logic [7:0] ch);
    codec_item_t it;
    it.command = cmd;
    it.entry_index = idx;
    it.entry_char = ech;
    it.char_in = ch;
    return it;
  endfunction

  // letters on the first four levels, spares marked '*', the rest spread
  function automatic logic [7:0] default_entry(int i);
    string level_chars;
    level_chars = "ETIANMSURWDKGOHVF*L*PJBXCYZQ**";
    if (i == 0) begin
      return "#";
    end else if (i <= 30) begin
      return level_chars[i - 1];
    end
    return 8'(i * 37 + 11);
  endfunction

  task automatic send_item(codec_item_t it);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= it.command;
    in_ch.entry_index <= it.entry_index;
    in_ch.entry_char <= it.entry_char;
    in_ch.char_in <= it.char_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_item(it);
    if (!(it.command == CMD_UNUSED
          || (it.command == mtc_pkg::CMD_LOAD && it.entry_index >= TABLE_SIZE))) begin
      items_sent++;
      if (items_sent % 40 == 0) begin
        send_burst = !send_burst;
      end
    end
  endtask

  task automatic send_op(logic [1:0] cmd, logic [7:0] ch);
    send_item(make_item(cmd, 8'($urandom), 8'($urandom), ch));
  endtask

  task automatic send_load(logic [7:0] idx, logic [7:0] ech);
    send_item(make_item(mtc_pkg::CMD_LOAD, idx, ech, 8'($urandom)));
  endtask

  task automatic send_morse(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_op(mtc_pkg::CMD_DECODE, s[i]);
    end
  endtask

  task automatic send_random_word();
    int n;
    int r;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) : $urandom_range(1, 7);
    repeat (n) begin
      send_op(mtc_pkg::CMD_DECODE,
              $urandom_range(0, 1) ? mtc_pkg::CH_DOT : mtc_pkg::CH_DASH);
    end
    r = $urandom_range(0, 9);
    if (r < 7) begin
      send_op(mtc_pkg::CMD_DECODE, mtc_pkg::CH_SEP);
    end else if (r == 7) begin
      send_op(mtc_pkg::CMD_DECODE, mtc_pkg::CH_SPACE);
    end else if (r == 8) begin
      send_op(mtc_pkg::CMD_DECODE, 8'($urandom));
    end else begin
      send_op(mtc_pkg::CMD_DECODE, mtc_pkg::CH_SEP);
      send_op(mtc_pkg::CMD_DECODE, mtc_pkg::CH_SPACE);
    end
  endtask

  task automatic send_random_encode();
    int r;
    logic [7:0] ch;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      ch = board.tree[$urandom_range(0, TABLE_SIZE - 1)];
    end else if (r == 6) begin
      ch = 8'($urandom_range(mtc_pkg::CH_LOWER_A, mtc_pkg::CH_LOWER_Z));
    end else if (r == 7) begin
      ch = $urandom_range(0, 1) ? mtc_pkg::CH_LF : mtc_pkg::CH_CR;
    end else begin
      ch = 8'($urandom);
    end
    send_op(mtc_pkg::CMD_ENCODE, ch);
  endtask

  initial begin
    int first;
    int pick;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.command <= mtc_pkg::CMD_LOAD;
    in_ch.entry_index <= 8'd0;
    in_ch.entry_char <= 8'd0;
    in_ch.char_in <= 8'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < TABLE_SIZE; i++) begin
      send_load(8'(i), default_entry(i));
    end

    send_load(8'hFF, "Q");
    send_op(mtc_pkg::CMD_ENCODE, "E");
    send_op(mtc_pkg::CMD_ENCODE, "q");
    send_op(mtc_pkg::CMD_ENCODE, mtc_pkg::CH_LOWER_A);
    send_op(mtc_pkg::CMD_ENCODE, mtc_pkg::CH_LOWER_Z);
    send_op(mtc_pkg::CMD_ENCODE, mtc_pkg::CH_LF);
    send_op(mtc_pkg::CMD_ENCODE, mtc_pkg::CH_CR);
    send_op(mtc_pkg::CMD_ENCODE, "#");
    send_op(mtc_pkg::CMD_ENCODE, "*");
    send_op(mtc_pkg::CMD_ENCODE, 8'hE6);
    send_load(8'd254, 8'hE6);
    send_op(mtc_pkg::CMD_ENCODE, 8'hE6);
    send_load(8'd127, 8'h00);
    send_op(mtc_pkg::CMD_ENCODE, 8'h00);
    send_load(8'd200, "E");
    send_op(mtc_pkg::CMD_ENCODE, "E");
    send_load(8'd7, "I");
    send_op(mtc_pkg::CMD_ENCODE, "I");
    send_morse(".-/");
    send_morse("/ ");
    send_morse("......./");
    send_morse("--------/");
    send_morse(".x/");
    send_item(make_item(CMD_UNUSED, 8'($urandom), 8'($urandom), mtc_pkg::CH_SPACE));

    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_random_encode();
      end else if (pick < 75) begin
        send_random_word();
      end else if (pick < 85) begin
        send_load(($urandom_range(0, 19) == 0) ? 8'hFF : 8'($urandom_range(0, TABLE_SIZE - 1)),
                  8'($urandom));
      end else if (pick < 95) begin
        send_op(mtc_pkg::CMD_DECODE, 8'($urandom));
      end else begin
        send_item(make_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom)));
      end
    end
    in_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (results_seen >= HOLD_AT_RESULT && !hold_done) begin
        gap = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        gap = take_burst ? 0 : $urandom_range(0, 10);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      board.check_output(out_ch.char_out, out_ch.last);
      results_seen++;
      if (results_seen % 40 == 0) begin
        take_burst = !take_burst;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hw/rtl/mtc_pkg.sv
hw/rtl/mtc_if.sv
hw/rtl/mtc_table.sv
hw/rtl/mtc_walk.sv
hw/rtl/morse_tree_codec.sv
tb/sv/morse_tree_codec_test.sv
